>>> rtl/core/mean_squared_error_loss_grad_assert.svh
// assertion macros for the mse loss and gradient block
`ifndef MEAN_SQUARED_ERROR_LOSS_GRAD_ASSERT_SVH
`define MEAN_SQUARED_ERROR_LOSS_GRAD_ASSERT_SVH

// same-cycle implication
`define MSEL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("msel assertion failed");

// next-cycle implication
`define MSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("msel assertion failed");

`endif

>>> rtl/core/msel_pkg.sv
// ----------------------------------------------------------------------------
// msel_pkg
// shared types and constants of the mse loss and gradient block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msel_pkg;

  localparam int unsigned MaxSampleElements = 4096;

  localparam int unsigned DataW    = 16;
  localparam int unsigned MagW     = 17;
  localparam int unsigned GradW    = 18;
  localparam int unsigned LossW    = 48;
  localparam int unsigned RecipW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MulAW    = 33;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 64;

  localparam logic [CfgIdxW-1:0] CfgReductionMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvSampleSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvBatchCount = 2'd2;

  localparam logic [RecipW-1:0] RecipReset = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAD,
    ST_SQ,
    ST_GMEAN,
    ST_GFIN,
    ST_SM_LO,
    ST_SM_HI,
    ST_SM_ADD,
    ST_BADD,
    ST_LS_LO,
    ST_LS_HI,
    ST_LS_ADD,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAG_ISS,
    MUL_MAG_MAG,
    MUL_M_IBC,
    MUL_SS_LO,
    MUL_SS_HI,
    MUL_BS_LO,
    MUL_BS_HI
  } mul_op_e;

  typedef enum logic [2:0] {
    POST_NONE,
    POST_SAVE_M,
    POST_SS_ADD,
    POST_GRAD,
    POST_ACC_LO,
    POST_ACC_HI,
    POST_BADD
  } post_op_e;

  typedef struct packed {
    logic     load;
    mul_op_e  mul_op;
    post_op_e post_op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic bend;
    logic mean;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/msel_ctrl.sv
// ----------------------------------------------------------------------------
// msel_ctrl
// sequencer that steps the shared multiplier through one transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msel_pkg::status_t status_i,
  output msel_pkg::cmd_t    cmd_o
);

  msel_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msel_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msel_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = msel_pkg::ST_GRAD;
      end
      msel_pkg::ST_GRAD:   state_d = msel_pkg::ST_SQ;
      msel_pkg::ST_SQ:     state_d = msel_pkg::ST_GMEAN;
      msel_pkg::ST_GMEAN:  state_d = msel_pkg::ST_GFIN;
      msel_pkg::ST_GFIN: begin
        priority if (status_i.close) begin
          state_d = msel_pkg::ST_SM_LO;
        end else begin
          state_d = msel_pkg::ST_DONE;
        end
      end
      msel_pkg::ST_SM_LO:  state_d = msel_pkg::ST_SM_HI;
      msel_pkg::ST_SM_HI:  state_d = msel_pkg::ST_SM_ADD;
      msel_pkg::ST_SM_ADD: state_d = msel_pkg::ST_BADD;
      msel_pkg::ST_BADD: begin
        priority if (status_i.bend && status_i.mean) begin
          state_d = msel_pkg::ST_LS_LO;
        end else begin
          state_d = msel_pkg::ST_DONE;
        end
      end
      msel_pkg::ST_LS_LO:  state_d = msel_pkg::ST_LS_HI;
      msel_pkg::ST_LS_HI:  state_d = msel_pkg::ST_LS_ADD;
      msel_pkg::ST_LS_ADD: state_d = msel_pkg::ST_DONE;
      msel_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = msel_pkg::ST_IDLE;
      end
      default:             state_d = msel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = msel_pkg::MUL_NONE;
    cmd_o.post_op  = msel_pkg::POST_NONE;
    in_stall_o     = 1'b1;
    unique case (state_q)
      msel_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      msel_pkg::ST_GRAD:   cmd_o.mul_op = msel_pkg::MUL_MAG_ISS;
      msel_pkg::ST_SQ: begin
        cmd_o.mul_op  = msel_pkg::MUL_MAG_MAG;
        cmd_o.post_op = msel_pkg::POST_SAVE_M;
      end
      msel_pkg::ST_GMEAN: begin
        cmd_o.mul_op  = msel_pkg::MUL_M_IBC;
        cmd_o.post_op = msel_pkg::POST_SS_ADD;
      end
      msel_pkg::ST_GFIN:   cmd_o.post_op = msel_pkg::POST_GRAD;
      msel_pkg::ST_SM_LO:  cmd_o.mul_op = msel_pkg::MUL_SS_LO;
      msel_pkg::ST_SM_HI: begin
        cmd_o.mul_op  = msel_pkg::MUL_SS_HI;
        cmd_o.post_op = msel_pkg::POST_ACC_LO;
      end
      msel_pkg::ST_SM_ADD: cmd_o.post_op = msel_pkg::POST_ACC_HI;
      msel_pkg::ST_BADD:   cmd_o.post_op = msel_pkg::POST_BADD;
      msel_pkg::ST_LS_LO:  cmd_o.mul_op = msel_pkg::MUL_BS_LO;
      msel_pkg::ST_LS_HI: begin
        cmd_o.mul_op  = msel_pkg::MUL_BS_HI;
        cmd_o.post_op = msel_pkg::POST_ACC_LO;
      end
      msel_pkg::ST_LS_ADD: cmd_o.post_op = msel_pkg::POST_ACC_HI;
      msel_pkg::ST_DONE:   cmd_o.out_load = status_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/msel_datapath.sv
// ----------------------------------------------------------------------------
// msel_datapath
// config registers, shared multiplier, accumulators and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msel_datapath #(
  parameter int unsigned MAX_SAMPLE_ELEMENTS = msel_pkg::MaxSampleElements
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msel_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [msel_pkg::RecipW-1:0]         cfg_wdata_i,
  input  logic signed [msel_pkg::DataW-1:0]   prediction_i,
  input  logic signed [msel_pkg::DataW-1:0]   target_i,
  input  logic                                sample_end_i,
  input  logic                                batch_end_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [msel_pkg::GradW-1:0]   gradient_o,
  output logic [msel_pkg::LossW-1:0]          loss_o,
  output logic                                loss_valid_o,
  input  msel_pkg::cmd_t                      cmd_i,
  output msel_pkg::status_t                   status_o
);

  localparam int unsigned CntW = (MAX_SAMPLE_ELEMENTS > 1) ? $clog2(MAX_SAMPLE_ELEMENTS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_SAMPLE_ELEMENTS - 1);

  localparam int unsigned MagW  = msel_pkg::MagW;
  localparam int unsigned MulAW = msel_pkg::MulAW;
  localparam int unsigned MulBW = msel_pkg::MulBW;
  localparam int unsigned ProdW = msel_pkg::ProdW;
  localparam int unsigned AccW  = msel_pkg::AccW;
  localparam int unsigned LossW = msel_pkg::LossW;
  localparam int unsigned GradW = msel_pkg::GradW;
  localparam int unsigned RW    = 20;

  localparam logic [LossW-1:0] LossMax   = {LossW{1'b1}};
  localparam logic [RW-1:0]    GradMax   = RW'(131071);
  localparam logic [RW-1:0]    GradMinMg = RW'(131072);

  // configuration
  logic                          mode_q;
  logic [msel_pkg::RecipW-1:0]   iss_q;
  logic [msel_pkg::RecipW-1:0]   ibc_q;

  // item
  logic [MagW-1:0]   mag_q;
  logic              neg_q;
  logic              close_q;
  logic              bend_q;
  logic [CntW-1:0]   cnt_q;

  // arithmetic
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  prod_q;
  logic [MulAW-1:0]  m_q;
  logic [AccW-1:0]   acc_q;
  logic [LossW-1:0]  sample_sum_q;
  logic [LossW-1:0]  batch_sum_q;
  logic [GradW-1:0]  grad_q;

  // output register
  logic              out_valid_q;
  logic [GradW-1:0]  out_grad_q;
  logic [LossW-1:0]  out_loss_q;
  logic              out_lvalid_q;

  logic signed [MagW-1:0] diff;
  logic [MagW-1:0]        diff_mag;
  logic [LossW:0]         ss_sum;
  logic [LossW:0]         bs_sum;
  logic [RW-1:0]          r_mean;
  logic [RW-1:0]          r_sum;
  logic [RW-1:0]          r_sel;
  logic [GradW-1:0]       grad_d;
  logic [LossW-1:0]       loss_d;
  logic                   mean_mode;

  assign mean_mode = (mode_q == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      iss_q  <= msel_pkg::RecipReset;
      ibc_q  <= msel_pkg::RecipReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msel_pkg::CfgReductionMode: mode_q <= cfg_wdata_i[0];
        msel_pkg::CfgInvSampleSize: iss_q  <= cfg_wdata_i;
        msel_pkg::CfgInvBatchCount: ibc_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign diff     = MagW'(target_i) - MagW'(prediction_i);
  assign diff_mag = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= diff_mag;
      neg_q   <= diff[MagW-1];
      close_q <= sample_end_i | batch_end_i | (cnt_q == CntLast);
      bend_q  <= batch_end_i;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      msel_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      msel_pkg::MUL_MAG_ISS: begin
        mul_a = MulAW'(mag_q);
        mul_b = MulBW'(iss_q);
      end
      msel_pkg::MUL_MAG_MAG: begin
        mul_a = MulAW'(mag_q);
        mul_b = mag_q;
      end
      msel_pkg::MUL_M_IBC: begin
        mul_a = m_q;
        mul_b = MulBW'(ibc_q);
      end
      msel_pkg::MUL_SS_LO: begin
        mul_a = MulAW'(sample_sum_q[31:0]);
        mul_b = MulBW'(iss_q);
      end
      msel_pkg::MUL_SS_HI: begin
        mul_a = MulAW'(sample_sum_q[LossW-1:32]);
        mul_b = MulBW'(iss_q);
      end
      msel_pkg::MUL_BS_LO: begin
        mul_a = MulAW'(batch_sum_q[31:0]);
        mul_b = MulBW'(ibc_q);
      end
      msel_pkg::MUL_BS_HI: begin
        mul_a = MulAW'(batch_sum_q[LossW-1:32]);
        mul_b = MulBW'(ibc_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  // gradient rounding and saturation
  assign r_mean = RW'((prod_q[48:0] + 49'(2**30)) >> 31);
  assign r_sum  = RW'((34'(m_q) + 34'(2**14)) >> 15);
  assign r_sel  = mean_mode ? r_mean : r_sum;

  always_comb begin
    if (neg_q) begin
      grad_d = (r_sel > GradMinMg) ? GradW'(GradMinMg) : GradW'(r_sel);
      grad_d = GradW'(-grad_d);
    end else begin
      grad_d = (r_sel > GradMax) ? GradW'(GradMax) : GradW'(r_sel);
    end
  end

  assign ss_sum = {1'b0, sample_sum_q} + (LossW+1)'(prod_q[33:0]);
  assign bs_sum = {1'b0, batch_sum_q} + (LossW+1)'(acc_q[AccW-1:16]);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.post_op)
      msel_pkg::POST_NONE:   ;
      msel_pkg::POST_SAVE_M: m_q <= prod_q[MulAW-1:0];
      msel_pkg::POST_GRAD:   grad_q <= grad_d;
      msel_pkg::POST_ACC_LO: acc_q <= AccW'(prod_q);
      msel_pkg::POST_ACC_HI: acc_q <= acc_q + {prod_q[31:0], 32'd0} + AccW'(2**15);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_sum_q <= '0;
      batch_sum_q  <= '0;
      cnt_q        <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= (sample_end_i | batch_end_i | (cnt_q == CntLast)) ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.post_op == msel_pkg::POST_SS_ADD) begin
        sample_sum_q <= ss_sum[LossW] ? LossMax : ss_sum[LossW-1:0];
      end
      if (cmd_i.post_op == msel_pkg::POST_BADD) begin
        batch_sum_q  <= bs_sum[LossW] ? LossMax : bs_sum[LossW-1:0];
        sample_sum_q <= '0;
      end
      if (cmd_i.out_load && bend_q) begin
        batch_sum_q <= '0;
      end
    end
  end

  assign loss_d = mean_mode ? acc_q[AccW-1:16] : batch_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_grad_q   <= grad_q;
      out_loss_q   <= bend_q ? loss_d : '0;
      out_lvalid_q <= bend_q;
    end
  end

  assign status_o.close    = close_q;
  assign status_o.bend     = bend_q;
  assign status_o.mean     = mean_mode;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign gradient_o   = out_grad_q;
  assign loss_o       = out_loss_q;
  assign loss_valid_o = out_lvalid_q;

endmodule

>>> rtl/core/mean_squared_error_loss_grad.sv
// ----------------------------------------------------------------------------
// mean_squared_error_loss_grad
// mse loss with per-element gradient over a stream of q8.8 pairs
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with prediction, target, sample_end
// and batch_end; one transaction per prediction/target pair.
// output channel: out_valid_o / out_stall_i; every input transaction gives
// one output transaction with the gradient, and on batch_end also the loss
// with loss_valid_o set (loss reads zero otherwise).
// the block takes no new pair until it has finished the last one and handed
// it to the output register; an item that closes a sample also scales the
// sample sum into the batch sum, and one that ends the batch in mean mode
// also scales the batch sum; all products go through one shared 33x17
// multiplier stepped by the controller.
// a stalled result holds in the output register; the block finishes the
// next item and then waits until that register is free. configuration
// (cfg_we_i, cfg_idx_i, cfg_wdata_i) is to be written by the user only while idle; the block does not enforce this.
// reset clears the sample and batch sums and the element count and loads the
// default configuration: mean mode, both reciprocals 0xffff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mean_squared_error_loss_grad #(
  parameter int unsigned MAX_SAMPLE_ELEMENTS = msel_pkg::MaxSampleElements
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msel_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [msel_pkg::RecipW-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [msel_pkg::DataW-1:0] prediction_i,
  input  logic signed [msel_pkg::DataW-1:0] target_i,
  input  logic                              sample_end_i,
  input  logic                              batch_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [msel_pkg::GradW-1:0] gradient_o,
  output logic [msel_pkg::LossW-1:0]        loss_o,
  output logic                              loss_valid_o
);

  msel_pkg::cmd_t    cmd;
  msel_pkg::status_t status;

  msel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msel_datapath #(
    .MAX_SAMPLE_ELEMENTS (MAX_SAMPLE_ELEMENTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .prediction_i (prediction_i),
    .target_i     (target_i),
    .sample_end_i (sample_end_i),
    .batch_end_i  (batch_end_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .gradient_o   (gradient_o),
    .loss_o       (loss_o),
    .loss_valid_o (loss_valid_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

`include "mean_squared_error_loss_grad_assert.svh"

  // busy right after a transaction is taken
  `MSEL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // a new result only appears while an item is in work
  `MSEL_ASSERT_IMPL(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  // loss field is zero unless it carries the batch result
  `MSEL_ASSERT_IMPL(a_loss_zero, clk_i, rst_ni, out_valid_o && !loss_valid_o, loss_o == '0)

endmodule

>>> tb/sv/mse_grad_loss_checker.sv
// ----------------------------------------------------------------------------
// mse_grad_loss_checker
// watches the pair and result channels of the mse loss and gradient block,
// tracks its configuration writes, predicts gradient and loss for every
// accepted pair and compares each accepted result field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mse_grad_loss_checker
  import msel_pkg::*;
#(
  parameter int unsigned MAX_SAMPLE_ELEMENTS = MaxSampleElements
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [RecipW-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [DataW-1:0]  prediction_i,
  input  logic signed [DataW-1:0]  target_i,
  input  logic                     sample_end_i,
  input  logic                     batch_end_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [GradW-1:0]  gradient_i,
  input  logic [LossW-1:0]         loss_i,
  input  logic                     loss_valid_i,
  output int                       errors_o,
  output int                       outstanding_o
);

  typedef struct packed {
    logic signed [GradW-1:0] gradient;
    logic [LossW-1:0]        loss;
    logic                    loss_valid;
  } grad_loss_t;

  localparam longint unsigned LossSat    = (64'd1 << LossW) - 64'd1;
  localparam longint unsigned GradPosMax = (64'd1 << (GradW - 1)) - 64'd1;
  localparam longint unsigned GradNegMag = 64'd1 << (GradW - 1);

  logic              sum_mode;
  logic [RecipW-1:0] inv_ss;
  logic [RecipW-1:0] inv_bc;
  longint unsigned   sample_acc;
  longint unsigned   batch_acc;
  int unsigned       elem_cnt;

  grad_loss_t grad_loss_q[$];
  int         pending = 0;
  int         result_idx = 0;
  int         errors = 0;

  assign errors_o      = errors;
  assign outstanding_o = pending;

  task automatic flag(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic longint unsigned sat_loss(input longint unsigned v);
    return (v > LossSat) ? LossSat : v;
  endfunction

  function automatic grad_loss_t compute_grad_loss(input logic signed [DataW-1:0] pred,
                                                   input logic signed [DataW-1:0] targ,
                                                   input logic s_end,
                                                   input logic b_end);
    int              diff;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned rnd;
    longint unsigned neg;
    longint unsigned smean;
    longint unsigned loss_val;
    grad_loss_t      res;
    diff = int'(targ) - int'(pred);
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * 64'd2 * inv_ss;
    if (sum_mode) begin
      rnd = (prod + (64'd1 << 15)) >> 16;
    end else begin
      rnd = (prod * inv_bc + (64'd1 << 31)) >> 32;
    end
    if (diff < 0) begin
      if (rnd > GradNegMag) rnd = GradNegMag;
      neg = 64'd0 - rnd;
      res.gradient = neg[GradW-1:0];
    end else begin
      if (rnd > GradPosMax) rnd = GradPosMax;
      res.gradient = rnd[GradW-1:0];
    end

    // squares accumulate per sample, sample means per batch
    sample_acc = sat_loss(sample_acc + mag * mag);
    elem_cnt++;
    if (s_end || b_end || elem_cnt >= MAX_SAMPLE_ELEMENTS) begin
      smean      = (sample_acc * inv_ss + (64'd1 << 15)) >> 16;
      batch_acc  = sat_loss(batch_acc + smean);
      sample_acc = 0;
      elem_cnt   = 0;
    end

    res.loss       = '0;
    res.loss_valid = 1'b0;
    if (b_end) begin
      loss_val = batch_acc;
      if (!sum_mode) begin
        loss_val = (batch_acc * inv_bc + (64'd1 << 15)) >> 16;
      end
      loss_val       = sat_loss(loss_val);
      res.loss       = loss_val[LossW-1:0];
      res.loss_valid = 1'b1;
      batch_acc      = 0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grad_loss_t want;
    if (!rst_ni) begin
      sum_mode   = 1'b0;
      inv_ss     = RecipReset;
      inv_bc     = RecipReset;
      sample_acc = 0;
      batch_acc  = 0;
      elem_cnt   = 0;
      grad_loss_q.delete();
      pending    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgReductionMode: sum_mode = cfg_wdata_i[0];
          CfgInvSampleSize: inv_ss = cfg_wdata_i;
          CfgInvBatchCount: inv_bc = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending == 0) begin
          flag($sformatf("result %0d arrived with no pair outstanding", result_idx));
        end else begin
          want = grad_loss_q.pop_front();
          pending--;
          if (gradient_i !== want.gradient) begin
            flag($sformatf("result %0d gradient: got %0d, expected %0d",
                           result_idx, gradient_i, want.gradient));
          end
          if (loss_i !== want.loss) begin
            flag($sformatf("result %0d loss: got %0d, expected %0d",
                           result_idx, loss_i, want.loss));
          end
          if (loss_valid_i !== want.loss_valid) begin
            flag($sformatf("result %0d loss_valid: got %0b, expected %0b",
                           result_idx, loss_valid_i, want.loss_valid));
          end
        end
        result_idx++;
      end
      if (in_valid_i && !in_stall_i) begin
        grad_loss_q.push_back(compute_grad_loss(prediction_i, target_i,
                                                sample_end_i, batch_end_i));
        pending++;
      end
    end
  end

endmodule

>>> tb/sv/tb_mean_squared_error_loss_grad.sv
// ----------------------------------------------------------------------------
// tb_mean_squared_error_loss_grad
// drives directed and random prediction/target streams into the mse loss and
// gradient block under several register settings and stall patterns, including
// gradient saturation and overlong samples; the checker
// beside the block predicts and compares every result transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mean_squared_error_loss_grad;
  import msel_pkg::*;

  localparam logic             ModeMean     = 1'b0;
  localparam logic             ModeSum      = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;
  localparam int unsigned      CycleLimit   = 400000;
  localparam int unsigned      SampleCap    = 16;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIdxW-1:0]      cfg_idx;
  logic [RecipW-1:0]       cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [DataW-1:0] prediction;
  logic signed [DataW-1:0] target;
  logic                    sample_end;
  logic                    batch_end;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [GradW-1:0] gradient;
  logic [LossW-1:0]        loss;
  logic                    loss_valid;

  int          errors;
  int          outstanding;
  int unsigned sender_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned pairs_sent = 0;
  int unsigned cycles = 0;

  mean_squared_error_loss_grad #(
    .MAX_SAMPLE_ELEMENTS (SampleCap)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .prediction_i (prediction),
    .target_i     (target),
    .sample_end_i (sample_end),
    .batch_end_i  (batch_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .gradient_o   (gradient),
    .loss_o       (loss),
    .loss_valid_o (loss_valid)
  );

  mse_grad_loss_checker #(
    .MAX_SAMPLE_ELEMENTS (SampleCap)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .prediction_i  (prediction),
    .target_i      (target),
    .sample_end_i  (sample_end),
    .batch_end_i   (batch_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .gradient_i    (gradient),
    .loss_i        (loss),
    .loss_valid_i  (loss_valid),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_pair(input logic [DataW-1:0] pred, input logic [DataW-1:0] targ,
                            input logic s_end, input logic b_end);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    prediction <= pred;
    target     <= targ;
    sample_end <= s_end;
    batch_end  <= b_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RecipW-1:0] val);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [RecipW-1:0] iss,
                            input logic [RecipW-1:0] ibc);
    write_reg(CfgReductionMode, {{(RecipW-1){1'b0}}, mode});
    write_reg(CfgInvSampleSize, iss);
    write_reg(CfgInvBatchCount, ibc);
  endtask

  function automatic logic [RecipW-1:0] pick_recip();
    int unsigned n;
    n = $urandom_range(2, 16);
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'd0;
      3:       return 16'($urandom);
      default: return 16'(65536 / n);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_q88();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 4))
      0, 1: return r[15:0];
      2:    return 16'(r[9:0]) - 16'd512;
      3:    return 16'(r[5:0]);
      default: begin
        case (r[1:0])
          2'd0:    return 16'h8000;
          2'd1:    return 16'h7FFF;
          2'd2:    return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // one batch of samples; mostly well formed, some with scrambled markers
  task automatic drive_batch();
    int unsigned      n_samp;
    int unsigned      len;
    logic [DataW-1:0] pred;
    logic [DataW-1:0] targ;
    logic             s_end;
    logic             b_end;
    logic             noisy;
    logic             open_end;
    n_samp   = $urandom_range(1, 4);
    noisy    = ($urandom_range(0, 99) < 10);
    open_end = ($urandom_range(0, 99) < 15);
    for (int s = 0; s < n_samp; s++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int e = 0; e < len; e++) begin
        pred = pick_q88();
        if ($urandom_range(0, 2) == 0) begin
          targ = pred + 16'($urandom_range(0, 63)) - 16'd32;
        end else begin
          targ = pick_q88();
        end
        s_end = (e == len - 1);
        b_end = s_end && (s == n_samp - 1);
        if (noisy) begin
          s_end = 1'($urandom_range(0, 1));
          b_end = b_end | ($urandom_range(0, 15) == 0);
        end
        if (b_end && open_end) s_end = 1'b0;
        drive_pair(pred, targ, s_end, b_end);
      end
    end
  endtask

  initial begin
    int unsigned seg_goal;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    prediction = '0;
    target     = '0;
    sample_end = 1'b0;
    batch_end  = 1'b0;
    out_stall  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 18;
    rx_idle_pct     = 56;

    // reset configuration: mean mode, both reciprocals at full scale
    drive_pair(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    drive_pair(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    drive_pair(16'h0000, 16'h0000, 1'b0, 1'b0);
    drive_pair(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    drive_pair(16'h0100, 16'h0080, 1'b0, 1'b1);
    drive_pair(16'h7FFF, 16'h8000, 1'b1, 1'b1);

    // sum mode, ties on the gradient rounding
    set_config(ModeSum, 16'd16384, 16'd0);
    drive_pair(16'h0000, 16'h0001, 1'b0, 1'b0);
    drive_pair(16'h0001, 16'h0000, 1'b1, 1'b0);
    drive_pair(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    drive_pair(16'h7FFF, 16'h8000, 1'b0, 1'b1);

    // zero reciprocals give zero contributions
    write_reg(CfgReductionMode, {{(RecipW-1){1'b0}}, ModeMean});
    drive_pair(16'h0000, 16'h0100, 1'b1, 1'b0);
    drive_pair(16'h0005, 16'hFFFB, 1'b0, 1'b1);
    write_reg(CfgInvSampleSize, 16'd0);
    drive_pair(16'h8000, 16'h7FFF, 1'b1, 1'b1);

    // unknown register index leaves the configuration alone
    write_reg(CfgUnusedIdx, 16'hFFFF);
    drive_pair(16'h1234, 16'h8765, 1'b0, 1'b1);

    set_config(ModeMean, 16'd1, 16'd1);
    drive_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    drive_pair(16'h7FFF, 16'h8000, 1'b1, 1'b1);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 0) begin
        set_config(ModeSum, 16'd1, 16'hFFFF);
      end else if (seg == 1) begin
        set_config(ModeMean, 16'hFFFF, 16'd1);
      end else begin
        set_config(logic'($urandom_range(0, 1)), pick_recip(), pick_recip());
      end
      if (seg < 2) begin
        sender_idle_pct = 18;
        rx_idle_pct     = 56;
      end else if (seg < 4) begin
        sender_idle_pct = 56;
        rx_idle_pct     = 18;
      end else begin
        sender_idle_pct = 0;
        rx_idle_pct     = 0;
      end
      seg_goal = pairs_sent + 115;
      while (pairs_sent < seg_goal) drive_batch();
    end

    // overlong samples close at the element cap without a marker
    set_config(ModeSum, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 2 * SampleCap + 3; i++) begin
      drive_pair(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    end
    drive_pair(16'h8000, 16'h7FFF, 1'b0, 1'b1);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
